### rtl/nor_flash_command_decoder_top_macros.svh
// Assertion macros for the NOR flash command decoder.
// Included by the top level; no other dependencies.
`ifndef NOR_FLASH_COMMAND_DECODER_TOP_MACROS_SVH
`define NOR_FLASH_COMMAND_DECODER_TOP_MACROS_SVH

`ifndef SYNTH
// expr must hold at every clock edge outside reset
`define NFCD_ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("nfcd assertion failed");
// ante implies cons in the same cycle
`define NFCD_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nfcd implication failed");
`else
`define NFCD_ASSERT_ALWAYS(name, clk, rst, expr)
`define NFCD_ASSERT_IMPLY(name, clk, rst, ante, cons)
`endif

`endif

### rtl/nfcd_pkg.sv
// Shared types and constants of the NOR flash command decoder.
// No dependencies.
`timescale 1ns / 1ps

package nfcd_pkg;

   localparam int ADDR_BITS   = 16;
   localparam int ARRAY_WORDS = 2 ** ADDR_BITS;
   localparam int WORD_BITS   = 16;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [15:0] UNLOCK_ADDR1 = 16'h5555;
   localparam logic [15:0] UNLOCK_ADDR2 = 16'h2AAA;

   localparam logic [7:0] CODE_UNLOCK1     = 8'hAA;
   localparam logic [7:0] CODE_UNLOCK2     = 8'h55;
   localparam logic [7:0] CODE_PROGRAM     = 8'hA0;
   localparam logic [7:0] CODE_ERASE_SETUP = 8'h80;
   localparam logic [7:0] CODE_CHIP_ERASE  = 8'h10;

   localparam logic [WORD_BITS-1:0] TOGGLE_MASK = 16'h0040;
   localparam logic [WORD_BITS-1:0] ERASED_WORD = 16'hFFFF;
   localparam logic [15:0]          PROGRAM_TICKS_RESET = 16'd10;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_U1,
      SEQ_U2,
      SEQ_ARMED,
      SEQ_E_SETUP,
      SEQ_E_U1,
      SEQ_E_U2
   } seq_state_type;

   typedef enum logic [1:0] {
      CTL_CLEAR,
      CTL_IDLE,
      CTL_EXEC
   } ctl_state_type;

   // events raised by the command sequence decoder
   typedef struct packed {
      logic prog_go;
      logic erase_go;
   } seq_evt_type;

endpackage

### rtl/nfcd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module nfcd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/nfcd_cmd_seq.sv
// Unlock / command sequence decoder of the NOR flash command decoder.
// Depends on nfcd_pkg.
`timescale 1ns / 1ps

module nfcd_cmd_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [nfcd_pkg::ADDR_BITS-1:0] addr,
   input  logic [7:0]                     code,
   output nfcd_pkg::seq_evt_type          evt
);

   import nfcd_pkg::*;

   seq_state_type state_ff;
   seq_state_type state_in;
   logic          at_u1;
   logic          at_u2;

   assign at_u1 = (addr == ADDR_BITS'(UNLOCK_ADDR1));
   assign at_u2 = (addr == ADDR_BITS'(UNLOCK_ADDR2));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      evt.prog_go  = 1'b0;
      evt.erase_go = 1'b0;
      if (wr_en) begin
         unique case (state_ff)
            SEQ_IDLE: begin
               state_in = (at_u1 && code == CODE_UNLOCK1) ? SEQ_U1 : SEQ_IDLE;
            end
            SEQ_U1: begin
               state_in = (at_u2 && code == CODE_UNLOCK2) ? SEQ_U2 : SEQ_IDLE;
            end
            SEQ_U2: begin
               if (at_u1 && code == CODE_PROGRAM) begin
                  state_in = SEQ_ARMED;
               end else if (at_u1 && code == CODE_ERASE_SETUP) begin
                  state_in = SEQ_E_SETUP;
               end else begin
                  state_in = SEQ_IDLE;
               end
            end
            SEQ_ARMED: begin
               // any write is the program data
               evt.prog_go = 1'b1;
               state_in    = SEQ_IDLE;
            end
            SEQ_E_SETUP: begin
               state_in = (at_u1 && code == CODE_UNLOCK1) ? SEQ_E_U1 : SEQ_IDLE;
            end
            SEQ_E_U1: begin
               state_in = (at_u2 && code == CODE_UNLOCK2) ? SEQ_E_U2 : SEQ_IDLE;
            end
            SEQ_E_U2: begin
               evt.erase_go = at_u1 && code == CODE_CHIP_ERASE;
               state_in     = SEQ_IDLE;
            end
            default: begin
               state_in = SEQ_IDLE;
            end
         endcase
      end
   end

endmodule

### rtl/nor_flash_command_decoder_top.sv
// Top level of the NOR flash command decoder: flash array RAM, sequence
// decoder and the program / erase / status control.
// Depends on nfcd_pkg, nfcd_ram, nfcd_cmd_seq and the macros header.
`timescale 1ns / 1ps
//
// Usage
// - Request channel: drive req_cmd (0 read, 1 write, 2 tick), req_word_addr and
//   req_write_data with start high; the word is taken at an edge where busy is low.
// - Response channel: one word per request on rsp_read_data / rsp_busy_res,
//   flagged by rsp_valid for exactly one cycle. The receiver cannot stall it.
// - CSR channel: csr_wdata sets program_ticks when csr_valid is high;
//   csr_ready is always high. Write only while no request is in flight.
// - Timing: the array word is read at the edge where a request is taken, the
//   update and write-back happen in the following execute cycle, and the
//   response shows in the cycle after. busy is high during execute, so no new
//   request is taken until the current one has left the execute state.
// - Reset: synchronous, active high. After reset the block sweeps the array
//   RAM to all ones, one word per cycle over 2**ADDR_BITS (65536) words, with busy
//   held high; CSR writes are still taken during the sweep.
// - Chip erase runs on ticks, one word per tick, sharing the sweep pointer.
//
module nor_flash_command_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_word_addr,
   input  logic [15:0] req_write_data,
   output logic        rsp_valid,
   output logic [15:0] rsp_read_data,
   output logic        rsp_busy_res,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);

   import nfcd_pkg::*;

`include "nor_flash_command_decoder_top_macros.svh"

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // latched request
   logic [1:0]           cmd_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [15:0]          data_ff;

   // operation state
   logic [15:0]        ticks_ff;
   logic [15:0]        busy_count_ff;
   logic [15:0]        busy_count_in;
   logic [ADDR_BITS:0] ptr_ff;        // erase pointer, also the reset sweep
   logic [ADDR_BITS:0] ptr_in;
   logic               erasing_ff;
   logic               erasing_in;
   logic               toggle_ff;
   logic               toggle_in;

   // response registers
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rsp_data_ff;
   logic [15:0] rsp_data_in;
   logic        rsp_busy_ff;
   logic        rsp_busy_in;

   // array RAM
   logic                 ram_we;
   logic [ADDR_BITS-1:0] ram_waddr;
   logic [15:0]          ram_wdata;
   logic [15:0]          ram_rdata;

   logic        accept;
   logic        op_busy;
   logic        ptr_last;
   logic        seq_wr;
   seq_evt_type seq_evt;

   assign accept    = start && !busy;
   assign busy      = (state_ff != CTL_IDLE);
   assign csr_ready = 1'b1;
   assign op_busy   = erasing_ff || (busy_count_ff != 16'd0);
   assign ptr_last  = (ptr_ff[ADDR_BITS-1:0] == {ADDR_BITS{1'b1}});
   assign seq_wr    = (state_ff == CTL_EXEC) && (cmd_ff == CMD_WRITE) && !op_busy;

   nfcd_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ARRAY_WORDS)
   ) u_array (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ADDR_BITS'(req_word_addr)),
      .rdata (ram_rdata)
   );

   nfcd_cmd_seq u_seq (
      .clock (clock),
      .reset (reset),
      .wr_en (seq_wr),
      .addr  (addr_ff),
      .code  (data_ff[7:0]),
      .evt   (seq_evt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CTL_CLEAR;
         ticks_ff      <= PROGRAM_TICKS_RESET;
         busy_count_ff <= 16'd0;
         ptr_ff        <= '0;
         erasing_ff    <= 1'b0;
         toggle_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_count_ff <= busy_count_in;
         ptr_ff        <= ptr_in;
         erasing_ff    <= erasing_in;
         toggle_ff     <= toggle_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            ticks_ff <= csr_wdata;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         addr_ff <= ADDR_BITS'(req_word_addr);
         data_ff <= req_write_data;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_busy_ff <= rsp_busy_in;
   end

   always_comb begin
      state_in      = state_ff;
      busy_count_in = busy_count_ff;
      ptr_in        = ptr_ff;
      erasing_in    = erasing_ff;
      toggle_in     = toggle_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = 16'd0;
      rsp_busy_in   = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = ptr_ff[ADDR_BITS-1:0];
      ram_wdata     = ERASED_WORD;

      unique case (state_ff)
         CTL_CLEAR: begin
            ram_we = 1'b1;
            ptr_in = ptr_last ? '0 : ptr_ff + 1'b1;
            if (ptr_last) begin
               state_in = CTL_IDLE;
            end
         end
         CTL_IDLE: begin
            if (accept) begin
               state_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            state_in     = CTL_IDLE;
            rsp_valid_in = 1'b1;
            unique case (cmd_ff)
               CMD_READ: begin
                  if (op_busy) begin
                     rsp_data_in = toggle_ff ? TOGGLE_MASK : 16'd0;
                     toggle_in   = !toggle_ff;
                  end else begin
                     rsp_data_in = ram_rdata;
                  end
               end
               CMD_WRITE: begin
                  if (seq_evt.prog_go) begin
                     ram_we        = 1'b1;
                     ram_waddr     = addr_ff;
                     ram_wdata     = ram_rdata & data_ff;
                     busy_count_in = (ticks_ff != 16'd0) ? ticks_ff : 16'd1;
                  end
                  if (seq_evt.erase_go) begin
                     erasing_in = 1'b1;
                     ptr_in     = '0;
                  end
               end
               CMD_TICK: begin
                  if (erasing_ff) begin
                     ram_we = 1'b1;
                     ptr_in = ptr_last ? '0 : ptr_ff + 1'b1;
                     if (ptr_last) begin
                        erasing_in = 1'b0;
                     end
                  end else if (busy_count_ff != 16'd0) begin
                     busy_count_in = busy_count_ff - 16'd1;
                  end
               end
               default: begin
                  // unknown command: no effect
               end
            endcase
            rsp_busy_in = erasing_in || (busy_count_in != 16'd0);
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_busy_res  = rsp_busy_ff;

   // each response follows an accepted request through execute and the response register
   `NFCD_ASSERT_IMPLY(a_rsp_follows_req, clock, reset, rsp_valid, $past(accept, 2))
   // the array is only written during the sweep or an execute cycle
   `NFCD_ASSERT_IMPLY(a_ram_we_phase, clock, reset, ram_we, state_ff != CTL_IDLE)
   // pointer never runs past the array
   `NFCD_ASSERT_ALWAYS(a_ptr_range, clock, reset, ptr_ff[ADDR_BITS] == 1'b0)

endmodule

### sim/nor_flash_command_decoder_top_tb.sv
// Self-checking testbench for nor_flash_command_decoder_top: bus reads, writes and
// ticks go in as request words and each response word is checked against a predictor.
// Depends on nfcd_pkg and the RTL of the decoder; reads no files.
`timescale 1ns / 1ps

module nor_flash_command_decoder_top_tb;
   import nfcd_pkg::*;

   localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
   localparam int         CLOCK_HALF   = 6;
   // The slowest legal run is about 1700 request words, each after its longest idle gap,
   // plus the clearing sweep after reset; this is roughly four times that.
   localparam int         CYCLE_LIMIT  = 400_000;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         MAX_REPORTS  = 10;
   localparam int         FILL_WORDS   = 400;
   localparam int         LONG_TICKS   = 150;
   localparam int         ERASE_TICKS  = 100;

   // chip erase command: six writes, step 0 in the low slot
   localparam logic [5:0][15:0] ERASE_ADDRS = {UNLOCK_ADDR1, UNLOCK_ADDR2, UNLOCK_ADDR1,
                                               UNLOCK_ADDR1, UNLOCK_ADDR2, UNLOCK_ADDR1};
   localparam logic [5:0][7:0]  ERASE_CODES = {CODE_CHIP_ERASE, CODE_UNLOCK2, CODE_UNLOCK1,
                                               CODE_ERASE_SETUP, CODE_UNLOCK2, CODE_UNLOCK1};

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] addr;
      logic [15:0] wdata;
   } bus_word_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        busy_res;
   } status_word_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        start          = 1'b0;
   logic [1:0]  req_cmd        = CMD_READ;
   logic [15:0] req_word_addr  = '0;
   logic [15:0] req_write_data = '0;
   logic        csr_valid      = 1'b0;
   logic [15:0] csr_wdata      = '0;
   logic        busy;
   logic        rsp_valid;
   logic [15:0] rsp_read_data;
   logic        rsp_busy_res;
   logic        csr_ready;

   nor_flash_command_decoder_top uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_word_addr  (req_word_addr),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_read_data  (rsp_read_data),
      .rsp_busy_res   (rsp_busy_res),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // ---------------------------------------------------------------------
   // Flash device predictor: its own array image, unlock state, busy
   // counters and copy of program_ticks.
   // ---------------------------------------------------------------------
   logic [15:0]   flash_image [ARRAY_WORDS];
   seq_state_type unlock_state  = SEQ_IDLE;
   logic [15:0]   program_left  = '0;
   logic [16:0]   erase_ptr     = '0;
   logic          erase_on      = 1'b0;
   logic          toggle_state  = 1'b0;
   logic [15:0]   program_ticks = PROGRAM_TICKS_RESET;

   function automatic logic device_busy();
      return erase_on || program_left != '0;
   endfunction

   // Applies one bus access to the image and returns the status word it yields.
   function automatic status_word_type flash_access(input bus_word_type w);
      status_word_type res;
      logic [7:0]      code;
      logic            at_first;
      logic            at_second;
      code      = w.wdata[7:0];          // command cycles look at the low byte only
      at_first  = w.addr == UNLOCK_ADDR1;
      at_second = w.addr == UNLOCK_ADDR2;
      res.read_data = '0;
      case (w.cmd)
         CMD_READ: begin
            if (device_busy()) begin
               res.read_data = toggle_state ? TOGGLE_MASK : '0;
               toggle_state  = ~toggle_state;
            end else begin
               res.read_data = flash_image[w.addr];
            end
         end
         CMD_WRITE: begin
            // writes while busy are dropped, unlock state untouched
            if (!device_busy()) begin
               case (unlock_state)
                  SEQ_IDLE:
                     unlock_state = (at_first && code == CODE_UNLOCK1) ? SEQ_U1 : SEQ_IDLE;
                  SEQ_U1:
                     unlock_state = (at_second && code == CODE_UNLOCK2) ? SEQ_U2 : SEQ_IDLE;
                  SEQ_U2: begin
                     if (at_first && code == CODE_PROGRAM)
                        unlock_state = SEQ_ARMED;
                     else if (at_first && code == CODE_ERASE_SETUP)
                        unlock_state = SEQ_E_SETUP;
                     else
                        unlock_state = SEQ_IDLE;
                  end
                  SEQ_ARMED: begin
                     // any write is the program data; zero ticks counts as one
                     flash_image[w.addr] = flash_image[w.addr] & w.wdata;
                     program_left = (program_ticks == '0) ? 16'd1 : program_ticks;
                     unlock_state = SEQ_IDLE;
                  end
                  SEQ_E_SETUP:
                     unlock_state = (at_first && code == CODE_UNLOCK1) ? SEQ_E_U1 : SEQ_IDLE;
                  SEQ_E_U1:
                     unlock_state = (at_second && code == CODE_UNLOCK2) ? SEQ_E_U2 : SEQ_IDLE;
                  SEQ_E_U2: begin
                     if (at_first && code == CODE_CHIP_ERASE) begin
                        erase_on  = 1'b1;
                        erase_ptr = '0;
                     end
                     unlock_state = SEQ_IDLE;
                  end
                  default: unlock_state = SEQ_IDLE;
               endcase
            end
         end
         CMD_TICK: begin
            if (erase_on) begin
               flash_image[erase_ptr[ADDR_BITS-1:0]] = ERASED_WORD;
               erase_ptr = erase_ptr + 1'b1;
               if (erase_ptr >= ARRAY_WORDS) begin
                  erase_ptr = '0;
                  erase_on  = 1'b0;
               end
            end else if (program_left != '0) begin
               program_left = program_left - 1'b1;
            end
         end
         default: ;                      // unknown command: no effect
      endcase
      res.busy_res = device_busy();
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Queues and counters shared by the driver, the monitor and the sequencer
   // ---------------------------------------------------------------------
   bus_word_type    pending_words [$];   // request words not yet taken by the block
   status_word_type awaited_status [$];  // predicted response words, oldest first
   int              mismatches  = 0;
   int              csr_writes  = 0;
   int              cycle_count = 0;
   int              gap_left    = 0;
   logic            word_taken  = 1'b0;
   logic            gaps_on     = 1'b1;

   // Monitor: everything here is sampled at the rising edge. Inputs only move
   // on the falling edge, so the values seen are the ones the block latched.
   always @(posedge clock) begin
      status_word_type want;
      bus_word_type    seen;
      if (reset) begin
         word_taken <= 1'b0;
      end else begin
         // response first: it always belongs to an earlier request word
         if (rsp_valid) begin
            if (awaited_status.size() == 0) begin
               if (mismatches < MAX_REPORTS)
                  $display("%0t: response word with none expected: read_data %h busy %b",
                           $time, rsp_read_data, rsp_busy_res);
               mismatches++;
            end else begin
               want = awaited_status.pop_front();
               if (rsp_read_data !== want.read_data || rsp_busy_res !== want.busy_res) begin
                  if (mismatches < MAX_REPORTS)
                     $display("%0t: read_data exp %h got %h, busy_res exp %b got %b",
                              $time, want.read_data, rsp_read_data, want.busy_res,
                              rsp_busy_res);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            seen.cmd   = req_cmd;
            seen.addr  = req_word_addr;
            seen.wdata = req_write_data;
            awaited_status.push_back(flash_access(seen));
         end
         word_taken <= start && !busy;
         if (csr_valid && csr_ready) begin
            program_ticks = csr_wdata;
            csr_writes++;
         end
      end
   end

   // Driver: presents the head of pending_words on the falling edge and holds
   // it until taken. Gaps only open after a word was taken or while start is
   // low, so start never drops under a word that is still waiting.
   always @(negedge clock) begin
      if (!reset) begin
         if (word_taken)
            void'(pending_words.pop_front());
         if (gap_left != 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_words.size() != 0 && gaps_on && (!start || word_taken) &&
                      $urandom_range(0, 11) == 0) begin
            gap_left = $urandom_range(0, 14);   // idle burst, start held low
            start <= 1'b0;
         end else if (pending_words.size() != 0) begin
            start          <= 1'b1;
            req_cmd        <= pending_words[0].cmd;
            req_word_addr  <= pending_words[0].addr;
            req_write_data <= pending_words[0].wdata;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_word(input logic [1:0] cmd, input logic [15:0] addr,
                             input logic [15:0] wdata);
      bus_word_type w;
      w.cmd   = cmd;
      w.addr  = addr;
      w.wdata = wdata;
      pending_words.push_back(w);
   endtask

   task automatic queue_ticks(input int count);
      for (int i = 0; i < count; i++)
         queue_word(CMD_TICK, 16'($urandom), 16'($urandom));
   endtask

   // One command cycle with random upper data byte; now and then a read
   // slips in ahead of it, which must not disturb the unlock state.
   task automatic queue_command(input logic [15:0] addr, input logic [7:0] code);
      logic [7:0] upper;
      upper = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0)
         queue_word(CMD_READ, addr, 16'($urandom));
      queue_word(CMD_WRITE, addr, {upper, code});
   endtask

   task automatic queue_program(input logic [15:0] addr, input logic [15:0] wdata);
      queue_command(UNLOCK_ADDR1, CODE_UNLOCK1);
      queue_command(UNLOCK_ADDR2, CODE_UNLOCK2);
      queue_command(UNLOCK_ADDR1, CODE_PROGRAM);
      queue_word(CMD_WRITE, addr, wdata);
   endtask

   // Addresses cluster at both ends of the array and on the unlock addresses,
   // so reads often land on words that were programmed.
   function automatic logic [15:0] pick_addr();
      logic [15:0] lane;
      lane = 16'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
         0:       return lane;
         1:       return ~lane;
         2:       return $urandom_range(0, 1) ? UNLOCK_ADDR1 : UNLOCK_ADDR2;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_data();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic write_program_ticks(input logic [15:0] value);
      int seen;
      seen = csr_writes;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      wait (csr_writes != seen);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every request is taken and answered, then let the pipeline settle.
   task automatic drain_words();
      while (pending_words.size() != 0 || awaited_status.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random traffic, mostly complete program commands with random content.
   // busy_ticks is the tick count that lets a program finish.
   task automatic fill_random(input int words, input int busy_ticks);
      int          target;
      int          k;
      logic [15:0] addr;
      logic [15:0] bad_addr;
      logic [7:0]  bad_code;
      target = pending_words.size() + words;
      while (pending_words.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               if ($urandom_range(0, 3) != 0)
                  queue_ticks(busy_ticks);
               addr = pick_addr();
               queue_program(addr, pick_data());
               k = $urandom_range(0, 3);
               for (int j = 0; j < k; j++)
                  queue_word(CMD_READ, addr, 16'($urandom));      // status toggles
               if ($urandom_range(0, 1) == 0)
                  queue_word(CMD_WRITE, pick_addr(), 16'($urandom));   // dropped if busy
               if ($urandom_range(0, 2) != 0) begin
                  queue_ticks(busy_ticks);
                  queue_word(CMD_READ, addr, 16'($urandom));
               end
            end
            6: begin
               // Broken command: a valid prefix, then one wrong write. The erase
               // table shares its first two steps with the program path.
               k = $urandom_range(0, 5);
               for (int j = 0; j < k; j++)
                  queue_command(ERASE_ADDRS[j], ERASE_CODES[j]);
               bad_addr = ERASE_ADDRS[k];
               bad_code = ERASE_CODES[k];
               if ($urandom_range(0, 1))
                  bad_addr = bad_addr ^ (16'h1 << $urandom_range(0, 15));
               else
                  bad_code = bad_code ^ 8'($urandom_range(1, 255));
               queue_command(bad_addr, bad_code);
               if ($urandom_range(0, 1))
                  queue_command(ERASE_ADDRS[k + (k < 5)], ERASE_CODES[k + (k < 5)]);
            end
            7: begin
               k = $urandom_range(1, 4);
               for (int j = 0; j < k; j++)
                  queue_word(CMD_READ, pick_addr(), 16'($urandom));
            end
            8: queue_ticks($urandom_range(1, 4));
            default: begin
               k = $urandom_range(1, 3);
               for (int j = 0; j < k; j++)
                  queue_word(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   initial begin
      logic [15:0] addr;
      logic [15:0] ticks;
      for (int i = 0; i < ARRAY_WORDS; i++)
         flash_image[ADDR_BITS'(i)] = ERASED_WORD;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, program_ticks still at its reset value. The block
      // holds these off while its clearing sweep runs.
      queue_word(CMD_READ, 16'hFFFF, 16'h0000);
      queue_word(CMD_TICK, 16'h0000, 16'hFFFF);        // tick while idle
      queue_word(CMD_UNKNOWN, 16'hFFFF, 16'hFFFF);     // unknown command
      queue_word(CMD_WRITE, UNLOCK_ADDR1, {8'hFF, CODE_UNLOCK1});
      queue_word(CMD_READ, UNLOCK_ADDR1, 16'h0000);    // read inside a sequence
      queue_word(CMD_WRITE, UNLOCK_ADDR2, {8'h00, CODE_UNLOCK2});
      queue_word(CMD_WRITE, UNLOCK_ADDR1, {8'h12, CODE_PROGRAM});
      queue_word(CMD_WRITE, 16'hFFFF, 16'h0000);       // armed: any address, any data
      queue_word(CMD_READ, 16'h0000, 16'hFFFF);        // status, toggle clear
      queue_word(CMD_READ, 16'h0000, 16'hFFFF);        // status, toggle set
      queue_word(CMD_WRITE, UNLOCK_ADDR1, {8'h00, CODE_UNLOCK1});  // dropped, busy
      queue_ticks(PROGRAM_TICKS_RESET);
      queue_word(CMD_READ, 16'hFFFF, 16'h0000);
      // broken sequence; the breaking write must not open a new one
      queue_word(CMD_WRITE, UNLOCK_ADDR1, {8'h00, CODE_UNLOCK1});
      queue_word(CMD_WRITE, UNLOCK_ADDR1, {8'h00, CODE_UNLOCK1});
      queue_word(CMD_WRITE, UNLOCK_ADDR2, {8'h00, CODE_UNLOCK2});
      queue_word(CMD_WRITE, UNLOCK_ADDR1, {8'h00, CODE_PROGRAM});
      queue_word(CMD_WRITE, 16'h1234, 16'h0000);
      queue_word(CMD_READ, 16'h1234, 16'h0000);
      drain_words();

      // zero ticks behaves as one
      write_program_ticks(16'd0);
      fill_random(FILL_WORDS, 1);
      drain_words();

      write_program_ticks(16'd1);
      fill_random(FILL_WORDS, 1);
      drain_words();

      // Long program: one word, then a full count of ticks with status
      // reads and dropped commands sprinkled in.
      write_program_ticks(16'(LONG_TICKS));
      queue_program(16'h00AB, 16'h5A0F);
      for (int i = 0; i < LONG_TICKS; i++) begin
         if (i % 16 == 0 || i == LONG_TICKS - 1)
            queue_word(CMD_READ, 16'h00AB, 16'($urandom));
         if (i % 32 == 1)
            queue_program(pick_addr(), 16'h0000);
         queue_word(CMD_TICK, 16'($urandom), 16'($urandom));
      end
      queue_word(CMD_READ, 16'h00AB, 16'($urandom));
      drain_words();

      // Last stretch runs back to back: random traffic, then the chip erase.
      gaps_on = 1'b0;
      ticks = 16'($urandom_range(3, 9));
      write_program_ticks(ticks);
      fill_random(FILL_WORDS, ticks);
      drain_words();

      // Chip erase: program both ends of the array, try an erase with a bad
      // final write, then start a real one. A full sweep takes 2**ADDR_BITS
      // ticks, so only its first part is run; reads then see status words.
      write_program_ticks(16'd2);
      for (int i = 0; i < 16; i++) begin
         addr = (i < 8) ? 16'(i) : ~16'(i - 8);
         queue_program(addr, pick_data() & 16'h7FFE);
         queue_ticks(2);
      end
      for (int j = 0; j < 5; j++)
         queue_command(ERASE_ADDRS[j], ERASE_CODES[j]);
      queue_command(UNLOCK_ADDR2, CODE_CHIP_ERASE);
      queue_word(CMD_READ, 16'h0000, 16'($urandom));
      for (int j = 0; j < 6; j++)
         queue_command(ERASE_ADDRS[j], ERASE_CODES[j]);
      for (int i = 0; i < ERASE_TICKS; i++) begin
         if (i % 16 == 0 || i == ERASE_TICKS - 1) begin
            queue_word(CMD_READ, pick_addr(), 16'($urandom));
            queue_word(CMD_WRITE, pick_addr(), 16'($urandom));
         end
         queue_word(CMD_TICK, 16'($urandom), 16'($urandom));
      end
      for (int i = 0; i < 16; i++)
         queue_word(CMD_READ, (i < 8) ? 16'(i) : ~16'(i - 8), 16'($urandom));
      drain_words();

      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
